/* design/obl_pkg.sv */
// ----------------------------------------------------------------------------
// obl_pkg
// Shared types and codes for the order book price-level update block.
// ----------------------------------------------------------------------------
package obl_pkg;

  // Update actions. Every other code is treated as a delete.
  localparam logic [1:0] CMD_NEW    = 2'd0;
  localparam logic [1:0] CMD_CHANGE = 2'd1;
  localparam logic [1:0] CMD_DELETE = 2'd2;

  // Book sides. Every other code is ignored.
  localparam logic [1:0] SIDE_BID = 2'd0;
  localparam logic [1:0] SIDE_ASK = 2'd1;

  // Result status codes.
  localparam logic [2:0] ST_APPLIED = 3'd0;
  localparam logic [2:0] ST_PRESENT = 3'd1;
  localparam logic [2:0] ST_ABSENT  = 3'd2;
  localparam logic [2:0] ST_IGNORED = 3'd3;
  localparam logic [2:0] ST_FULL    = 3'd4;

  // One market-data entry.
  typedef struct packed {
    logic [1:0]  cmd;
    logic [1:0]  side;
    logic [31:0] price;
    logic [31:0] quantity;
  } obl_in_t;

  // One result.
  typedef struct packed {
    logic [2:0] status;
    logic [6:0] level_count;
  } obl_out_t;

  // Control from the sequencer to the compare unit.
  typedef struct packed {
    logic clear;
    logic issue;
  } scan_ctl_t;

  // Status from the compare unit back to the sequencer.
  typedef struct packed {
    logic found;
    logic free_seen;
  } scan_stat_t;

endpackage

/* design/obl_ram.sv */
// ----------------------------------------------------------------------------
// obl_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module obl_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 128,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* design/obl_scan.sv */
// ----------------------------------------------------------------------------
// obl_scan
// Shared compare unit: checks one stored level per cycle against the key,
// remembering the first matching slot and the lowest free slot of the side.
// ----------------------------------------------------------------------------
module obl_scan
  import obl_pkg::*;
#(
  parameter int SW = 6,
  parameter int PW = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  scan_ctl_t     ctl,
  input  logic [SW-1:0] slot,
  input  logic          entry_valid,
  input  logic [PW-1:0] rd_price,
  input  logic [PW-1:0] key,
  output scan_stat_t    stat,
  output logic [SW-1:0] found_slot,
  output logic [SW-1:0] free_slot
);

  logic          chk_vld_r, chk_vld_nxt;
  logic [SW-1:0] chk_slot_r;
  logic          chk_valid_r;
  logic          found_r, found_nxt;
  logic          free_r, free_nxt;
  logic [SW-1:0] found_slot_r, found_slot_nxt;
  logic [SW-1:0] free_slot_r, free_slot_nxt;

  // Compare the entry whose read data arrives this cycle.
  always_comb begin
    chk_vld_nxt    = ctl.issue;
    found_nxt      = found_r;
    free_nxt       = free_r;
    found_slot_nxt = found_slot_r;
    free_slot_nxt  = free_slot_r;
    if (ctl.clear) begin
      chk_vld_nxt = 1'b0;
      found_nxt   = 1'b0;
      free_nxt    = 1'b0;
    end else if (chk_vld_r) begin
      if (chk_valid_r && (rd_price == key) && !found_r) begin
        found_nxt      = 1'b1;
        found_slot_nxt = chk_slot_r;
      end
      if (!chk_valid_r && !free_r) begin
        free_nxt      = 1'b1;
        free_slot_nxt = chk_slot_r;
      end
    end
  end

  // Control flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chk_vld_r <= 1'b0;
      found_r   <= 1'b0;
      free_r    <= 1'b0;
    end else begin
      chk_vld_r <= chk_vld_nxt;
      found_r   <= found_nxt;
      free_r    <= free_nxt;
    end
  end

  // Slot numbers travel alongside the read, aligned with the RAM latency.
  always_ff @(posedge clk) begin
    chk_slot_r   <= slot;
    chk_valid_r  <= entry_valid;
    found_slot_r <= found_slot_nxt;
    free_slot_r  <= free_slot_nxt;
  end

  assign stat.found     = found_r;
  assign stat.free_seen = free_r;
  assign found_slot     = found_slot_r;
  assign free_slot      = free_slot_r;

endmodule

/* design/order_book_level_update_top.sv */
// ----------------------------------------------------------------------------
// order_book_level_update_top
// Bid and ask price-level tables updated by one market-data entry at a time.
// ----------------------------------------------------------------------------
// An entry is taken when start is high and busy is low. For each entry on a bid
// or ask side, the sequencer reads every stored level of the side through the
// single read port of the price RAM, one level a cycle, then passes through a
// wait state for the last compare and an update state for the write back. An
// entry with an ignored side goes straight to the update state. The result is
// shown for exactly one cycle with out_strobe high and cannot be held off; busy
// is already low in that cycle, so a new entry may be started alongside it.
// Both tables are empty after reset with no clearing pass.
module order_book_level_update_top
  import obl_pkg::*;
#(
  parameter int LEVELS_PER_SIDE = 64,
  parameter int PRICE_BITS      = 32,
  parameter int QTY_BITS        = 32
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  obl_in_t  in_item,
  output logic     out_strobe,
  output obl_out_t out_item
);

  localparam int L     = LEVELS_PER_SIDE;
  localparam int DEPTH = 2 * L;
  localparam int AW    = $clog2(DEPTH);
  localparam int SW    = $clog2(L);
  localparam int CW    = $clog2(L + 1);
  localparam int EW    = PRICE_BITS + QTY_BITS;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_WAIT   = 2'd2;
  localparam logic [1:0] S_UPDATE = 2'd3;

  logic [1:0]            state_r, state_nxt;
  logic [SW-1:0]         idx_r, idx_nxt;
  logic [1:0]            cmd_r;
  logic                  ask_r;
  logic                  ign_r;
  logic [PRICE_BITS-1:0] key_r;
  logic [QTY_BITS-1:0]   qty_r;
  logic [DEPTH-1:0]      valid_r, valid_nxt;
  logic [CW-1:0]         bid_cnt_r, bid_cnt_nxt;
  logic [CW-1:0]         ask_cnt_r, ask_cnt_nxt;
  logic                  strobe_r, strobe_nxt;
  obl_out_t              out_r, out_nxt;

  logic                  accept;
  logic [63:0]           price_ext;
  logic [63:0]           qty_ext;
  logic [AW-1:0]         base;
  logic [AW-1:0]         rd_addr;
  logic [AW-1:0]         wr_addr;
  logic                  wr_en;
  logic [EW-1:0]         rd_data;
  scan_ctl_t             ctl;
  scan_stat_t            stat;
  logic [SW-1:0]         found_slot;
  logic [SW-1:0]         free_slot;
  logic [SW-1:0]         wr_slot;
  logic [CW-1:0]         cnt_cur;
  logic [CW-1:0]         cnt_new;

  assign accept    = start && !busy;
  assign busy      = (state_r != S_IDLE);
  assign price_ext = 64'(in_item.price);
  assign qty_ext   = 64'(in_item.quantity);

  // Slots 0 to L-1 hold the bid side, L to 2L-1 the ask side.
  assign base    = ask_r ? AW'(L) : '0;
  assign rd_addr = base + AW'(idx_r);
  assign wr_slot = stat.found ? found_slot : free_slot;
  assign wr_addr = base + AW'(wr_slot);
  assign cnt_cur = ask_r ? ask_cnt_r : bid_cnt_r;

  // Compare unit control.
  assign ctl.clear = accept;
  assign ctl.issue = (state_r == S_SCAN);

  // Price and quantity of each level share one RAM word.
  obl_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_level_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data ({key_r, qty_r}),
    .rd_en   (ctl.issue),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  obl_scan #(
    .SW (SW),
    .PW (PRICE_BITS)
  ) u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (ctl),
    .slot        (idx_r),
    .entry_valid (valid_r[rd_addr]),
    .rd_price    (rd_data[EW-1:QTY_BITS]),
    .key         (key_r),
    .stat        (stat),
    .found_slot  (found_slot),
    .free_slot   (free_slot)
  );

  // Sequencer: scan the side, finish the last compare, then apply the update.
  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    valid_nxt   = valid_r;
    bid_cnt_nxt = bid_cnt_r;
    ask_cnt_nxt = ask_cnt_r;
    strobe_nxt  = 1'b0;
    out_nxt     = out_r;
    wr_en       = 1'b0;
    cnt_new     = cnt_cur;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          idx_nxt   = '0;
          state_nxt = ((in_item.side == SIDE_BID) || (in_item.side == SIDE_ASK)) ?
                      S_SCAN : S_UPDATE;
        end
      end
      S_SCAN: begin
        idx_nxt = idx_r + SW'(1);
        if (idx_r == SW'(L - 1)) begin
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        state_nxt = S_UPDATE;
      end
      S_UPDATE: begin
        state_nxt  = S_IDLE;
        strobe_nxt = 1'b1;
        if (ign_r) begin
          out_nxt.status = ST_IGNORED;
          cnt_new        = '0;
        end else begin
          unique case (cmd_r)
            CMD_NEW: begin
              if (stat.found) begin
                out_nxt.status = ST_PRESENT;
              end else if (!stat.free_seen) begin
                out_nxt.status = ST_FULL;
              end else begin
                wr_en              = 1'b1;
                valid_nxt[wr_addr] = 1'b1;
                cnt_new            = cnt_cur + CW'(1);
                out_nxt.status     = ST_APPLIED;
              end
            end
            CMD_CHANGE: begin
              if (stat.found) begin
                wr_en          = 1'b1;
                out_nxt.status = ST_APPLIED;
              end else begin
                out_nxt.status = ST_ABSENT;
              end
            end
            default: begin
              if (stat.found) begin
                valid_nxt[wr_addr] = 1'b0;
                cnt_new            = cnt_cur - CW'(1);
                out_nxt.status     = ST_APPLIED;
              end else begin
                out_nxt.status = ST_ABSENT;
              end
            end
          endcase
          if (ask_r) begin
            ask_cnt_nxt = cnt_new;
          end else begin
            bid_cnt_nxt = cnt_new;
          end
        end
        out_nxt.level_count = 7'(cnt_new);
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      valid_r   <= '0;
      bid_cnt_r <= '0;
      ask_cnt_r <= '0;
      strobe_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      valid_r   <= valid_nxt;
      bid_cnt_r <= bid_cnt_nxt;
      ask_cnt_r <= ask_cnt_nxt;
      strobe_r  <= strobe_nxt;
    end
  end

  // Entry and result payload.
  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    out_r <= out_nxt;
    if (accept) begin
      cmd_r <= in_item.cmd;
      ask_r <= (in_item.side == SIDE_ASK);
      ign_r <= !((in_item.side == SIDE_BID) || (in_item.side == SIDE_ASK));
      key_r <= price_ext[PRICE_BITS-1:0];
      qty_r <= qty_ext[QTY_BITS-1:0];
    end
  end

  assign out_strobe = strobe_r;
  assign out_item   = out_r;

`ifndef SYNTHESIS
  // A result is only shown once the block is free again.
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result shown while busy");

  // A transfer always starts a busy period.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("entry transfer did not raise busy");

  // Level counts never exceed the side capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (bid_cnt_r <= CW'(L)) && (ask_cnt_r <= CW'(L)))
    else $error("level count above capacity");

  // An ignored side reports no levels.
  a_ignored_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_item.status == ST_IGNORED)) |-> (out_item.level_count == 7'd0))
    else $error("ignored side reported levels");

  // Each update cycle yields exactly one result in the following cycle.
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPDATE) |=> out_strobe)
    else $error("update without result");
`endif

endmodule
